### src/rpm_pkg.sv
package rpm_pkg;

  localparam int unsigned MAP_ENTRIES = 256;
  localparam int unsigned PAGE_BYTES  = 4096;
  localparam int unsigned FRAME_BITS  = 20;

  localparam int unsigned SLOT_BITS   = $clog2(MAP_ENTRIES);
  localparam int unsigned OFFSET_BITS = $clog2(PAGE_BYTES);
  localparam int unsigned BYTES_BITS  = OFFSET_BITS + 1;
  localparam int unsigned USED_BITS   = $clog2(MAP_ENTRIES + 1);
  localparam int unsigned REF_BITS    = 16;
  localparam int unsigned ADDR_BITS   = 32;
  localparam int unsigned REQ_BITS    = 32;
  localparam int unsigned STATUS_BITS = 2;

  localparam logic KIND_MAP   = 1'b0;
  localparam logic KIND_UNMAP = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_HIT     = 2'd0,
    STATUS_NEW     = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_UNKNOWN = 2'd3
  } rpm_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } rpm_state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } rpm_cmd_t;

  typedef struct packed {
    logic skip;
    logic scan_last;
    logic out_busy;
  } rpm_sts_t;

endpackage

### src/rpm_req_if.sv
interface rpm_req_if import rpm_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [FRAME_BITS-1:0] page_frame;
  logic [OFFSET_BITS-1:0] page_offset;
  logic [REQ_BITS-1:0]   request_bytes;

  modport source (output valid, kind, page_frame, page_offset, request_bytes, input ready);
  modport sink (input valid, kind, page_frame, page_offset, request_bytes, output ready);
endinterface

### src/rpm_rsp_if.sv
interface rpm_rsp_if import rpm_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [SLOT_BITS-1:0]   slot;
  logic [ADDR_BITS-1:0]   bus_address;
  logic [BYTES_BITS-1:0]  byte_count;
  logic                   iomap_write;
  logic                   slot_freed;

  modport source (output valid, status, slot, bus_address, byte_count, iomap_write,
                  slot_freed, input ready);
  modport sink (input valid, status, slot, bus_address, byte_count, iomap_write,
                slot_freed, output ready);
endinterface

### src/rpm_ctrl.sv
module rpm_ctrl import rpm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  rpm_sts_t sts_i,
  output rpm_cmd_t cmd_o
);

  rpm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.skip ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### src/rpm_datapath.sv
module rpm_datapath import rpm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [ADDR_BITS-1:0]   cfg_wdata_i,
  input  rpm_cmd_t               cmd_i,
  output rpm_sts_t               sts_o,
  input  logic                   req_kind_i,
  input  logic [FRAME_BITS-1:0]  req_page_frame_i,
  input  logic [OFFSET_BITS-1:0] req_page_offset_i,
  input  logic [REQ_BITS-1:0]    req_request_bytes_i,
  input  logic                   rsp_ready_i,
  output logic                   rsp_valid_o,
  output logic [STATUS_BITS-1:0] rsp_status_o,
  output logic [SLOT_BITS-1:0]   rsp_slot_o,
  output logic [ADDR_BITS-1:0]   rsp_bus_address_o,
  output logic [BYTES_BITS-1:0]  rsp_byte_count_o,
  output logic                   rsp_iomap_write_o,
  output logic                   rsp_slot_freed_o
);

  localparam logic [REF_BITS-1:0] RefsMax = '1;
  localparam logic [SLOT_BITS-1:0] LastSlot = SLOT_BITS'(MAP_ENTRIES - 1);

  logic [FRAME_BITS-1:0] frame_mem [MAP_ENTRIES];
  logic [REF_BITS-1:0]   refs_mem  [MAP_ENTRIES];
  logic [MAP_ENTRIES-1:0] valid_q, valid_d;
  logic [USED_BITS-1:0]  used_q, used_d;
  logic [ADDR_BITS-1:0]  window_q;

  logic                   kind_q;
  logic [FRAME_BITS-1:0]  frame_q;
  logic [OFFSET_BITS-1:0] off_q;
  logic [BYTES_BITS-1:0]  bytes_q;
  logic                   refuse_q;

  logic [SLOT_BITS-1:0]  scan_addr_q;
  logic                  rd_vld_q;
  logic [SLOT_BITS-1:0]  rd_slot_q;
  logic                  rd_valid_q;
  logic [FRAME_BITS-1:0] frame_rd_q;
  logic [REF_BITS-1:0]   refs_rd_q;

  logic                  found_q;
  logic [SLOT_BITS-1:0]  match_q;
  logic [REF_BITS-1:0]   match_refs_q;
  logic                  hole_found_q;
  logic [SLOT_BITS-1:0]  hole_q;

  logic                   rsp_valid_q;
  rpm_status_e            status_q;
  logic [SLOT_BITS-1:0]   slot_q;
  logic [ADDR_BITS-1:0]   bus_q;
  logic [BYTES_BITS-1:0]  mbytes_q;
  logic                   iomap_q;
  logic                   freed_q;

  logic [BYTES_BITS-1:0] left;
  logic [BYTES_BITS-1:0] req_bytes;
  logic                  is_match;
  logic                  is_hole;

  rpm_status_e           fin_status;
  logic [SLOT_BITS-1:0]  fin_slot;
  logic [BYTES_BITS-1:0] fin_bytes;
  logic                  fin_iomap;
  logic                  fin_freed;
  logic                  fin_addr_en;
  logic                  frame_we;
  logic                  refs_we;
  logic [REF_BITS-1:0]   refs_wdata;

  assign left      = BYTES_BITS'(PAGE_BYTES) - {1'b0, req_page_offset_i};
  assign req_bytes = (req_request_bytes_i <= REQ_BITS'(left))
                     ? req_request_bytes_i[BYTES_BITS-1:0] : left;

  assign sts_o.skip = (req_kind_i == KIND_MAP)
                      && ((used_q >= USED_BITS'(MAP_ENTRIES - 1)) || (req_page_frame_i == '0));
  assign sts_o.scan_last = (scan_addr_q == LastSlot);
  assign sts_o.out_busy  = rsp_valid_q && !rsp_ready_i;

  assign is_match = rd_vld_q && rd_valid_q && !found_q && (frame_q != '0)
                    && (frame_rd_q == frame_q);
  assign is_hole  = rd_vld_q && !rd_valid_q && !hole_found_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= req_kind_i;
      frame_q <= req_page_frame_i;
      off_q   <= req_page_offset_i;
      bytes_q <= req_bytes;
    end
    rd_slot_q <= scan_addr_q;
    if (is_match) begin
      match_q      <= rd_slot_q;
      match_refs_q <= refs_rd_q;
    end
    if (is_hole) begin
      hole_q <= rd_slot_q;
    end
    if (cmd_i.finish) begin
      status_q <= fin_status;
      slot_q   <= fin_slot;
      bus_q    <= fin_addr_en ? window_q + ADDR_BITS'({fin_slot, off_q}) : '0;
      mbytes_q <= fin_bytes;
      iomap_q  <= fin_iomap;
      freed_q  <= fin_freed;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_we) begin
      frame_mem[fin_slot] <= frame_q;
    end
    frame_rd_q <= frame_mem[scan_addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (refs_we) begin
      refs_mem[fin_slot] <= refs_wdata;
    end
    refs_rd_q <= refs_mem[scan_addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q     <= '0;
      valid_q      <= '0;
      used_q       <= '0;
      refuse_q     <= 1'b0;
      scan_addr_q  <= '0;
      rd_vld_q     <= 1'b0;
      rd_valid_q   <= 1'b0;
      found_q      <= 1'b0;
      hole_found_q <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      valid_q    <= valid_d;
      used_q     <= used_d;
      rd_vld_q   <= cmd_i.scan;
      rd_valid_q <= valid_q[scan_addr_q];
      if (cmd_i.load) begin
        refuse_q     <= sts_o.skip;
        scan_addr_q  <= '0;
        found_q      <= 1'b0;
        hole_found_q <= 1'b0;
      end else begin
        if (cmd_i.scan) begin
          scan_addr_q <= scan_addr_q + 1'b1;
        end
        if (is_match) begin
          found_q <= 1'b1;
        end
        if (is_hole) begin
          hole_found_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    fin_status  = STATUS_FULL;
    fin_slot    = match_q;
    fin_bytes   = '0;
    fin_iomap   = 1'b0;
    fin_freed   = 1'b0;
    fin_addr_en = 1'b0;
    frame_we    = 1'b0;
    refs_we     = 1'b0;
    refs_wdata  = match_refs_q;
    valid_d     = valid_q;
    used_d      = used_q;
    if (kind_q == KIND_MAP) begin
      if (refuse_q) begin
        fin_status = STATUS_FULL;
      end else if (found_q) begin
        fin_status  = STATUS_HIT;
        fin_bytes   = bytes_q;
        fin_addr_en = 1'b1;
        refs_we     = cmd_i.finish;
        if (match_refs_q != RefsMax) begin
          refs_wdata = match_refs_q + 1'b1;
        end
      end else if (hole_found_q) begin
        fin_status  = STATUS_NEW;
        fin_slot    = hole_q;
        fin_bytes   = bytes_q;
        fin_iomap   = 1'b1;
        fin_addr_en = 1'b1;
        frame_we    = cmd_i.finish;
        refs_we     = cmd_i.finish;
        refs_wdata  = REF_BITS'(1);
        if (cmd_i.finish) begin
          valid_d[hole_q] = 1'b1;
          used_d          = used_q + 1'b1;
        end
      end
    end else begin
      if (!found_q) begin
        fin_status = STATUS_UNKNOWN;
      end else begin
        fin_status  = STATUS_HIT;
        fin_addr_en = 1'b1;
        if (match_refs_q <= REF_BITS'(1)) begin
          fin_freed = 1'b1;
          if (cmd_i.finish) begin
            valid_d[match_q] = 1'b0;
            if (used_q != '0) begin
              used_d = used_q - 1'b1;
            end
          end
        end else begin
          refs_we    = cmd_i.finish;
          refs_wdata = match_refs_q - 1'b1;
        end
      end
    end
    if (!fin_addr_en) begin
      fin_slot = '0;
    end
  end

  assign rsp_valid_o        = rsp_valid_q;
  assign rsp_status_o       = status_q;
  assign rsp_slot_o         = slot_q;
  assign rsp_bus_address_o  = bus_q;
  assign rsp_byte_count_o   = mbytes_q;
  assign rsp_iomap_write_o  = iomap_q;
  assign rsp_slot_freed_o   = freed_q;

endmodule

### src/refcounted_io_page_map.sv
// Reference-counted I/O page map. Each request word maps or unmaps one host page in a
// 256-slot bus window and returns one result word with the slot, the bus address and
// the bytes mapped within the page. A request that scans the table walks it one slot per
// cycle through the single read port of the slot table, and the next request is accepted
// only after it finishes; a map request refused as table full skips the scan.
// A finished result waits in an output register, so the next request is accepted while
// it is pending; that request finishes only once the pending word has been taken. Slot
// occupancy is held in flip-flops cleared by reset, so no clearing pass follows reset.
// The window offset may be written only while the block is idle.
module refcounted_io_page_map import rpm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [ADDR_BITS-1:0] cfg_wdata_i,
  rpm_req_if.sink              req_i,
  rpm_rsp_if.source            rsp_o
);

  rpm_cmd_t cmd;
  rpm_sts_t sts;

  rpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rpm_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .req_kind_i          (req_i.kind),
    .req_page_frame_i    (req_i.page_frame),
    .req_page_offset_i   (req_i.page_offset),
    .req_request_bytes_i (req_i.request_bytes),
    .rsp_ready_i         (rsp_o.ready),
    .rsp_valid_o         (rsp_o.valid),
    .rsp_status_o        (rsp_o.status),
    .rsp_slot_o          (rsp_o.slot),
    .rsp_bus_address_o   (rsp_o.bus_address),
    .rsp_byte_count_o    (rsp_o.byte_count),
    .rsp_iomap_write_o   (rsp_o.iomap_write),
    .rsp_slot_freed_o    (rsp_o.slot_freed)
  );

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(cmd.finish))
    else $error("result word appeared without a finish step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while the previous one is still in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.scan && sts.scan_last) |=> !cmd.scan)
    else $error("table scan ran past the last slot");
`endif

endmodule
